// ===== sv/xsmu_pkg.sv =====
// ----------------------------------------------------------------------------
// xsmu_pkg
// Types, codes and helper functions for the x86 signed multiply unit.
// ----------------------------------------------------------------------------
package xsmu_pkg;

   localparam int unsigned DATA_WIDTH      = 64;
   localparam int unsigned HALF_WIDTH      = DATA_WIDTH / 2;
   localparam int unsigned BYTE_PROD_WIDTH = 16;

   // operation form
   localparam logic OP_TRUNC = 1'b0;
   localparam logic OP_WIDEN = 1'b1;

   // operand width codes
   localparam logic [1:0] WIDTH_8  = 2'd0;
   localparam logic [1:0] WIDTH_16 = 2'd1;
   localparam logic [1:0] WIDTH_32 = 2'd2;
   localparam logic [1:0] WIDTH_64 = 2'd3;

   // immediate size codes
   localparam logic [1:0] IMM_FULL = 2'd0;
   localparam logic [1:0] IMM_8    = 2'd1;
   localparam logic [1:0] IMM_16   = 2'd2;
   localparam logic [1:0] IMM_32   = 2'd3;

   // result status
   localparam logic STATUS_DONE  = 1'b0;
   localparam logic STATUS_FAULT = 1'b1;

   typedef struct packed {
      logic                  op;
      logic [1:0]            width_code;
      logic [1:0]            imm_size;
      logic [DATA_WIDTH-1:0] lhs_operand;
      logic [DATA_WIDTH-1:0] rhs_operand;
      logic                  operand_fault;
   } req_type;

   typedef struct packed {
      logic                  status;
      logic [DATA_WIDTH-1:0] product_low;
      logic [DATA_WIDTH-1:0] product_high;
      logic                  write_high;
      logic                  overflow;
   } rsp_type;

   // sign-extend the low 8/16/32 bits of x, or pass all 64
   function automatic logic [DATA_WIDTH-1:0] sext_by_code(
      input logic [DATA_WIDTH-1:0] x,
      input logic [1:0]            code
   );
      logic [DATA_WIDTH-1:0] r;
      case (code)
         WIDTH_8:  r = {{56{x[7]}}, x[7:0]};
         WIDTH_16: r = {{48{x[15]}}, x[15:0]};
         WIDTH_32: r = {{32{x[31]}}, x[31:0]};
         default:  r = x;
      endcase
      return r;
   endfunction

   function automatic logic [DATA_WIDTH-1:0] low_mask(input logic [1:0] code);
      logic [DATA_WIDTH-1:0] r;
      case (code)
         WIDTH_8:  r = {56'd0, 8'hFF};
         WIDTH_16: r = {48'd0, 16'hFFFF};
         WIDTH_32: r = {32'd0, 32'hFFFF_FFFF};
         default:  r = '1;
      endcase
      return r;
   endfunction

endpackage

// ===== sv/x86_signed_multiply_unit.sv =====
// ----------------------------------------------------------------------------
// x86_signed_multiply_unit
// Pipelined x86 IMUL: truncating and widening forms, 8 to 64 bit operands.
// ----------------------------------------------------------------------------
// Takes one multiply every clock cycle; busy is always low. Each transfer
// returns exactly one result, in order. rsp_valid rises once the transfer has
// passed the stage 0 to stage 3 registers and the output register, and stays high
// for one cycle per result. The stages compute the 64x64
// product: operands are sign-extended and registered, split into four 32x32
// partial products, summed into 128 bits, sign-corrected, then formatted with
// the overflow flag into the output register. The receiver cannot stall, so
// there is no back-pressure anywhere in the pipe. A faulted operand read
// comes back with fault status and all other fields zero.
module x86_signed_multiply_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  xsmu_pkg::req_type req_payload,
   output logic              rsp_valid,
   output xsmu_pkg::rsp_type rsp_payload
);

   localparam int unsigned DW = xsmu_pkg::DATA_WIDTH;
   localparam int unsigned HW = xsmu_pkg::HALF_WIDTH;

   typedef struct packed {
      logic       op;
      logic [1:0] width_code;
      logic       fault;
   } ctl_type;

   // ---------------- stage 0: operand sign extension ----------------
   logic          s0_vld_ff,  s0_vld_in;
   ctl_type       s0_ctl_ff,  s0_ctl_in;
   logic [DW-1:0] s0_a_ff,    s0_a_in;
   logic [DW-1:0] s0_b_ff,    s0_b_in;
   logic [1:0]    imm_code;
   logic [1:0]    rhs_code;

   assign busy = 1'b0;

   always_comb begin
      s0_vld_in = start & ~busy;
      s0_ctl_in.op         = req_payload.op;
      s0_ctl_in.width_code = req_payload.width_code;
      s0_ctl_in.fault      = req_payload.operand_fault;
      // immediate size 8/16/32 maps onto width code 0/1/2
      imm_code = req_payload.imm_size - 2'd1;
      rhs_code = req_payload.width_code;
      if (req_payload.op == xsmu_pkg::OP_TRUNC &&
          req_payload.imm_size != xsmu_pkg::IMM_FULL &&
          imm_code < req_payload.width_code) begin
         rhs_code = imm_code;
      end
      s0_a_in = xsmu_pkg::sext_by_code(req_payload.lhs_operand, req_payload.width_code);
      s0_b_in = xsmu_pkg::sext_by_code(req_payload.rhs_operand, rhs_code);
   end

   // ---------------- stage 1: partial products ----------------
   logic          s1_vld_ff;
   ctl_type       s1_ctl_ff;
   logic [DW-1:0] s1_ll_ff, s1_ll_in;
   logic [DW-1:0] s1_lh_ff, s1_lh_in;
   logic [DW-1:0] s1_hl_ff, s1_hl_in;
   logic [DW-1:0] s1_hh_ff, s1_hh_in;
   logic [DW-1:0] s1_corr_ff, s1_corr_in;

   always_comb begin
      s1_ll_in = s0_a_ff[HW-1:0]  * s0_b_ff[HW-1:0];
      s1_lh_in = s0_a_ff[HW-1:0]  * s0_b_ff[DW-1:HW];
      s1_hl_in = s0_a_ff[DW-1:HW] * s0_b_ff[HW-1:0];
      s1_hh_in = s0_a_ff[DW-1:HW] * s0_b_ff[DW-1:HW];
      // signed correction of the unsigned high half
      s1_corr_in = (s0_a_ff[DW-1] ? s0_b_ff : '0) + (s0_b_ff[DW-1] ? s0_a_ff : '0);
   end

   // ---------------- stage 2: 128-bit unsigned sum ----------------
   logic            s2_vld_ff;
   ctl_type         s2_ctl_ff;
   logic [2*DW-1:0] s2_prod_ff, s2_prod_in;
   logic [DW-1:0]   s2_corr_ff;

   always_comb begin
      s2_prod_in = {s1_hh_ff, s1_ll_ff}
                 + {{HW{1'b0}}, s1_lh_ff, {HW{1'b0}}}
                 + {{HW{1'b0}}, s1_hl_ff, {HW{1'b0}}};
   end

   // ---------------- stage 3: sign correction ----------------
   logic          s3_vld_ff;
   ctl_type       s3_ctl_ff;
   logic [DW-1:0] s3_lo_ff, s3_lo_in;
   logic [DW-1:0] s3_hi_ff, s3_hi_in;

   always_comb begin
      s3_lo_in = s2_prod_ff[DW-1:0];
      s3_hi_in = s2_prod_ff[2*DW-1:DW] - s2_corr_ff;
   end

   // ---------------- stage 4: format and flags ----------------
   logic              rsp_valid_ff;
   xsmu_pkg::rsp_type rsp_payload_ff, rsp_payload_in;
   logic [DW-1:0]     mask;
   logic              ovf;

   always_comb begin
      mask = xsmu_pkg::low_mask(s3_ctl_ff.width_code);
      if (s3_ctl_ff.width_code == xsmu_pkg::WIDTH_64) begin
         ovf = s3_hi_ff != {DW{s3_lo_ff[DW-1]}};
      end else begin
         ovf = xsmu_pkg::sext_by_code(s3_lo_ff, s3_ctl_ff.width_code) != s3_lo_ff;
      end

      rsp_payload_in.status       = xsmu_pkg::STATUS_DONE;
      rsp_payload_in.product_low  = s3_lo_ff & mask;
      rsp_payload_in.product_high = '0;
      rsp_payload_in.write_high   = 1'b0;
      rsp_payload_in.overflow     = ovf;

      if (s3_ctl_ff.op == xsmu_pkg::OP_WIDEN) begin
         case (s3_ctl_ff.width_code)
            xsmu_pkg::WIDTH_8: begin
               rsp_payload_in.product_low =
                  {{(DW-xsmu_pkg::BYTE_PROD_WIDTH){1'b0}},
                   s3_lo_ff[xsmu_pkg::BYTE_PROD_WIDTH-1:0]};
            end
            xsmu_pkg::WIDTH_16: begin
               rsp_payload_in.product_high = {48'd0, s3_lo_ff[31:16]};
               rsp_payload_in.write_high   = 1'b1;
            end
            xsmu_pkg::WIDTH_32: begin
               rsp_payload_in.product_high = {32'd0, s3_lo_ff[63:32]};
               rsp_payload_in.write_high   = 1'b1;
            end
            default: begin
               rsp_payload_in.product_high = s3_hi_ff;
               rsp_payload_in.write_high   = 1'b1;
            end
         endcase
      end

      if (s3_ctl_ff.fault) begin
         rsp_payload_in.status       = xsmu_pkg::STATUS_FAULT;
         rsp_payload_in.product_low  = '0;
         rsp_payload_in.product_high = '0;
         rsp_payload_in.write_high   = 1'b0;
         rsp_payload_in.overflow     = 1'b0;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff    <= 1'b0;
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         s3_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s0_vld_ff    <= s0_vld_in;
         s1_vld_ff    <= s0_vld_ff;
         s2_vld_ff    <= s1_vld_ff;
         s3_vld_ff    <= s2_vld_ff;
         rsp_valid_ff <= s3_vld_ff;
      end
   end

   // datapath, no reset needed
   always_ff @(posedge clock) begin
      s0_ctl_ff      <= s0_ctl_in;
      s0_a_ff        <= s0_a_in;
      s0_b_ff        <= s0_b_in;
      s1_ctl_ff      <= s0_ctl_ff;
      s1_ll_ff       <= s1_ll_in;
      s1_lh_ff       <= s1_lh_in;
      s1_hl_ff       <= s1_hl_in;
      s1_hh_ff       <= s1_hh_in;
      s1_corr_ff     <= s1_corr_in;
      s2_ctl_ff      <= s1_ctl_ff;
      s2_prod_ff     <= s2_prod_in;
      s2_corr_ff     <= s1_corr_ff;
      s3_ctl_ff      <= s2_ctl_ff;
      s3_lo_ff       <= s3_lo_in;
      s3_hi_ff       <= s3_hi_in;
      rsp_payload_ff <= rsp_payload_in;
   end

`ifndef SYNTHESIS
   a_rsp_from_transfer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 5))
      else $error("result strobe without a matching transfer");

   a_transfer_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##5 rsp_valid)
      else $error("transfer produced no result");

   a_high_only_widen: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.write_high) |->
         $past(req_payload.op == xsmu_pkg::OP_WIDEN &&
               req_payload.width_code != xsmu_pkg::WIDTH_8, 5))
      else $error("high half written for a form that has none");

   a_fault_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status == xsmu_pkg::STATUS_FAULT) |->
         (rsp_payload.product_low == '0 && rsp_payload.product_high == '0 &&
          !rsp_payload.write_high && !rsp_payload.overflow))
      else $error("faulted result carries data");
`endif

endmodule

// ===== dv/xsmu_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// xsmu_checker
// Watches both channels of the signed multiply unit, computes the expected
// result of every accepted multiply and compares it field by field, in order,
// with each result that comes back.
// ----------------------------------------------------------------------------
module xsmu_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  xsmu_pkg::req_type req_payload,
   input  logic              rsp_valid,
   input  xsmu_pkg::rsp_type rsp_payload,
   output int                fail_count,
   output int                outstanding,
   output int                results_seen,
   output int                overflow_seen
);

   xsmu_pkg::rsp_type expected_products[$];

   // sign-extend the low bits of x into a 128-bit signed value
   function automatic logic signed [127:0] extend_signed(input logic [63:0] x,
                                                         input int unsigned bits);
      logic signed [127:0] t;
      t = {64'd0, x};
      t = t <<< (128 - bits);
      return t >>> (128 - bits);
   endfunction

   function automatic xsmu_pkg::rsp_type imul_result(input xsmu_pkg::req_type r);
      xsmu_pkg::rsp_type   res;
      int unsigned         w;
      int unsigned         rhs_bits;
      logic signed [127:0] a;
      logic signed [127:0] b;
      logic signed [127:0] prod;
      logic [127:0]        upper;
      logic [63:0]         mask;
      res = '0;
      if (r.operand_fault) begin
         res.status = xsmu_pkg::STATUS_FAULT;
         return res;
      end
      w = 8 << r.width_code;
      rhs_bits = w;
      // an immediate wider than the operand is in effect cut to the operand width
      if (r.op == xsmu_pkg::OP_TRUNC && r.imm_size != xsmu_pkg::IMM_FULL &&
          (4 << r.imm_size) < rhs_bits) begin
         rhs_bits = 4 << r.imm_size;
      end
      a = extend_signed(r.lhs_operand, w);
      b = extend_signed(r.rhs_operand, rhs_bits);
      prod = a * b;
      mask = (w == 64) ? '1 : ((64'd1 << w) - 64'd1);
      res.status = xsmu_pkg::STATUS_DONE;
      res.overflow = (prod != extend_signed(prod[63:0], w));
      res.product_low = prod[63:0] & mask;
      if (r.op == xsmu_pkg::OP_WIDEN) begin
         if (r.width_code == xsmu_pkg::WIDTH_8) begin
            res.product_low = {48'd0, prod[15:0]};
         end else begin
            upper = prod >> w;
            res.product_high = upper[63:0] & mask;
            res.write_high = 1'b1;
         end
      end
      return res;
   endfunction

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : monitor
      xsmu_pkg::rsp_type want;
      if (reset) begin
         expected_products.delete();
         fail_count = 0;
         results_seen = 0;
         overflow_seen = 0;
      end else begin
         if (rsp_valid) begin
            if (expected_products.size() == 0) begin
               fail_count++;
               $display("%0t: result with nothing outstanding, got %h", $time, rsp_payload);
            end else begin
               want = expected_products.pop_front();
               check_field("status", 64'(want.status), 64'(rsp_payload.status));
               check_field("product_low", want.product_low, rsp_payload.product_low);
               check_field("product_high", want.product_high, rsp_payload.product_high);
               check_field("write_high", 64'(want.write_high),
                           64'(rsp_payload.write_high));
               check_field("overflow", 64'(want.overflow), 64'(rsp_payload.overflow));
               results_seen++;
               if (want.overflow) overflow_seen++;
            end
         end
         if (start && !busy) begin
            expected_products.push_back(imul_result(req_payload));
         end
      end
      outstanding <= expected_products.size();
   end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the x86 signed multiply unit.
// Sends directed corner multiplies, then random ones, mostly with random sender gaps,
// while the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;

   localparam int ITEM_COUNT   = 1800;
   localparam int QUIET_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = 12;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   xsmu_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   xsmu_pkg::rsp_type rsp_payload;

   int fail_count;
   int outstanding;
   int results_seen;
   int overflow_seen;
   int items_sent;
   int widen_sent;
   int faults_sent;
   bit gaps_on = 1'b1;

   always #2 clock = ~clock;

   x86_signed_multiply_unit dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   xsmu_checker imul_check (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_payload   (rsp_payload),
      .fail_count    (fail_count),
      .outstanding   (outstanding),
      .results_seen  (results_seen),
      .overflow_seen (overflow_seen)
   );

   function automatic xsmu_pkg::req_type imul_req(input logic op,
                                                  input logic [1:0] width_code,
                                                  input logic [1:0] imm_size,
                                                  input logic [63:0] lhs,
                                                  input logic [63:0] rhs,
                                                  input logic fault);
      xsmu_pkg::req_type r;
      r.op = op;
      r.width_code = width_code;
      r.imm_size = imm_size;
      r.lhs_operand = lhs;
      r.rhs_operand = rhs;
      r.operand_fault = fault;
      return r;
   endfunction

   // mix of plain random, small signed, and width extremes
   function automatic logic [63:0] random_operand();
      logic [63:0] v;
      int unsigned k;
      k = $urandom_range(3);
      case ($urandom_range(9))
         0, 1, 2, 3: v = {$urandom, $urandom};
         4:          v = 64'($signed($urandom_range(32)) - 16);
         5:          v = '1;
         6:          v = '0;
         7:          v = 64'd1 << ((8 << k) - 1);
         8:          v = (64'd1 << ((8 << k) - 1)) - 64'd1;
         default:    v = {$urandom, $urandom} >> $urandom_range(63);
      endcase
      return v;
   endfunction

   // drive at the falling edge, return at the edge that completes the transfer
   task automatic issue(input xsmu_pkg::req_type r);
      @(negedge clock);
      if (gaps_on) begin
         while ($urandom_range(99) < 19) begin
            start <= 1'b0;
            @(negedge clock);
         end
      end
      start <= 1'b1;
      req_payload <= r;
      while (busy) @(negedge clock);
      @(posedge clock);
      items_sent++;
      if (r.operand_fault) faults_sent++;
      else if (r.op == xsmu_pkg::OP_WIDEN) widen_sent++;
   endtask

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((start && !busy) || rsp_valid) quiet = 0;
         else quiet++;
      end
      $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
      $display("tb: errors");
      $finish;
   end

   initial begin : stimulus
      xsmu_pkg::req_type r;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // truncating 64-bit corners
      issue(imul_req(xsmu_pkg::OP_TRUNC, xsmu_pkg::WIDTH_64, xsmu_pkg::IMM_FULL,
                     64'd0, 64'd0, 1'b0));
      issue(imul_req(xsmu_pkg::OP_TRUNC, xsmu_pkg::WIDTH_64, xsmu_pkg::IMM_FULL,
                     64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0));
      issue(imul_req(xsmu_pkg::OP_TRUNC, xsmu_pkg::WIDTH_64, xsmu_pkg::IMM_FULL,
                     64'h8000_0000_0000_0000, '1, 1'b0));
      issue(imul_req(xsmu_pkg::OP_TRUNC, xsmu_pkg::WIDTH_64, xsmu_pkg::IMM_FULL,
                     '1, '1, 1'b0));
      // immediates carry garbage above their size
      issue(imul_req(xsmu_pkg::OP_TRUNC, xsmu_pkg::WIDTH_64, xsmu_pkg::IMM_8,
                     64'd123456789, 64'h1234_5678_9ABC_DE80, 1'b0));
      issue(imul_req(xsmu_pkg::OP_TRUNC, xsmu_pkg::WIDTH_64, xsmu_pkg::IMM_16,
                     64'h0123_4567_89AB_CDEF, 64'hAAAA_AAAA_AAAA_8000, 1'b0));
      issue(imul_req(xsmu_pkg::OP_TRUNC, xsmu_pkg::WIDTH_64, xsmu_pkg::IMM_32,
                     64'h8000_0000_0000_0000, 64'h5555_5555_8000_0000, 1'b0));
      issue(imul_req(xsmu_pkg::OP_TRUNC, xsmu_pkg::WIDTH_32, xsmu_pkg::IMM_FULL,
                     64'hDEAD_BEEF_7FFF_FFFF, 64'd2, 1'b0));
      issue(imul_req(xsmu_pkg::OP_TRUNC, xsmu_pkg::WIDTH_32, xsmu_pkg::IMM_32,
                     64'h0000_0000_8000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0));
      // immediate wider and narrower than the operand
      issue(imul_req(xsmu_pkg::OP_TRUNC, xsmu_pkg::WIDTH_16, xsmu_pkg::IMM_32,
                     64'h0000_0000_0000_1234, 64'h0000_0000_0001_8001, 1'b0));
      issue(imul_req(xsmu_pkg::OP_TRUNC, xsmu_pkg::WIDTH_16, xsmu_pkg::IMM_8,
                     64'h0000_0000_0000_8000, 64'h7F, 1'b0));
      // byte truncating form
      issue(imul_req(xsmu_pkg::OP_TRUNC, xsmu_pkg::WIDTH_8, xsmu_pkg::IMM_FULL,
                     64'h80, 64'hFF, 1'b0));
      issue(imul_req(xsmu_pkg::OP_TRUNC, xsmu_pkg::WIDTH_8, xsmu_pkg::IMM_8,
                     64'hFFFF_FFFF_FFFF_FF7F, 64'h7F, 1'b0));
      issue(imul_req(xsmu_pkg::OP_TRUNC, xsmu_pkg::WIDTH_8, xsmu_pkg::IMM_16,
                     64'h05, 64'h0000_0000_0000_FF83, 1'b0));
      // widening forms, immediate size ignored
      issue(imul_req(xsmu_pkg::OP_WIDEN, xsmu_pkg::WIDTH_8, xsmu_pkg::IMM_FULL,
                     64'h80, 64'h80, 1'b0));
      issue(imul_req(xsmu_pkg::OP_WIDEN, xsmu_pkg::WIDTH_8, xsmu_pkg::IMM_8,
                     64'h7F, 64'h81, 1'b0));
      issue(imul_req(xsmu_pkg::OP_WIDEN, xsmu_pkg::WIDTH_16, xsmu_pkg::IMM_32,
                     64'h8000, 64'h8000, 1'b0));
      issue(imul_req(xsmu_pkg::OP_WIDEN, xsmu_pkg::WIDTH_32, xsmu_pkg::IMM_16,
                     64'hFFFF_FFFF, 64'd1, 1'b0));
      issue(imul_req(xsmu_pkg::OP_WIDEN, xsmu_pkg::WIDTH_32, xsmu_pkg::IMM_FULL,
                     64'h8000_0000, 64'h8000_0000, 1'b0));
      issue(imul_req(xsmu_pkg::OP_WIDEN, xsmu_pkg::WIDTH_64, xsmu_pkg::IMM_FULL,
                     64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 1'b0));
      issue(imul_req(xsmu_pkg::OP_WIDEN, xsmu_pkg::WIDTH_64, xsmu_pkg::IMM_8,
                     64'h7FFF_FFFF_FFFF_FFFF, '1, 1'b0));
      issue(imul_req(xsmu_pkg::OP_WIDEN, xsmu_pkg::WIDTH_64, xsmu_pkg::IMM_FULL,
                     64'd0, '1, 1'b0));
      // faulted operand reads
      issue(imul_req(xsmu_pkg::OP_TRUNC, xsmu_pkg::WIDTH_64, xsmu_pkg::IMM_32,
                     '1, '1, 1'b1));
      issue(imul_req(xsmu_pkg::OP_WIDEN, xsmu_pkg::WIDTH_64, xsmu_pkg::IMM_FULL,
                     64'h8000_0000_0000_0000, '1, 1'b1));

      for (int i = 0; i < ITEM_COUNT; i++) begin
         // one long stretch with back-to-back transfers
         gaps_on = !(i >= 600 && i < 900);
         r.op = 1'($urandom_range(1));
         r.width_code = 2'($urandom_range(3));
         r.imm_size = 2'($urandom_range(3));
         r.lhs_operand = random_operand();
         r.rhs_operand = random_operand();
         r.operand_fault = ($urandom_range(19) == 0);
         issue(r);
      end

      @(negedge clock);
      start <= 1'b0;
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d multiplies: %0d widening, %0d faulted, rest truncating",
               items_sent, widen_sent, faults_sent);
      $display("%0d results compared, %0d with overflow set, %0d mismatches",
               results_seen, overflow_seen, fail_count);
      if (fail_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
